>>> rtl/core/sdre_pkg.sv
package sdre_pkg;

    // Digit store geometry
    localparam int NUM_DIGITS = 8;
    localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);

    // Request operation codes
    localparam logic [1:0] OP_WRITE_DIGIT = 2'd0;
    localparam logic [1:0] OP_REFRESH     = 2'd1;
    localparam logic [1:0] OP_INIT        = 2'd2;

    // Controller command bytes
    localparam logic [7:0] CMD_DATA_AUTO  = 8'h44;
    localparam logic [7:0] CMD_DISP_CTRL  = 8'h88;
    localparam logic [7:0] CMD_ADDR_BASE  = 8'hC0;
    localparam logic [7:0] CMD_DATA_FIXED = 8'h40;

    // Byte position inside one refresh row
    localparam logic [1:0] PH_ADDR = 2'd0;
    localparam logic [1:0] PH_CMD  = 2'd1;
    localparam logic [1:0] PH_COL  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REFRESH,
        ST_INIT
    } seq_state_t;

    // Hex nibble to segment pattern (bit 0 = segment a)
    function automatic logic [7:0] seg_font(input logic [3:0] nib);
        logic [7:0] pat;
        case (nib)
            4'h0:    pat = 8'b00111111;
            4'h1:    pat = 8'b00000110;
            4'h2:    pat = 8'b01011011;
            4'h3:    pat = 8'b01001111;
            4'h4:    pat = 8'b01100110;
            4'h5:    pat = 8'b01101101;
            4'h6:    pat = 8'b01111101;
            4'h7:    pat = 8'b00000111;
            4'h8:    pat = 8'b01111111;
            4'h9:    pat = 8'b01101111;
            4'hA:    pat = 8'b01110111;
            4'hB:    pat = 8'b01111100;
            4'hC:    pat = 8'b00111001;
            4'hD:    pat = 8'b01011110;
            4'hE:    pat = 8'b01111001;
            default: pat = 8'b01110001;
        endcase
        return pat;
    endfunction

endpackage

>>> rtl/core/segment_display_refresh_engine.sv
// Write-digit request: stored at the accepting edge, no output bytes; one request per cycle.
// Refresh request: 24 bytes, the first registered after the state register enters refresh,
// then one per cycle while the output is not stalled; no request is taken during a refresh.
// Initialize request: 2 bytes, one per cycle unless stalled. Next request accepted
// once the last byte is in the output register. Async active-low reset blanks all digits,
// sets brightness to 1 and empties the output register.
module segment_display_refresh_engine (
    input  logic        clk,
    input  logic        rst_n,
    // request: [1:0] operation, [4:2] digit_index, [8:5] hex_value, rest zero
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    // result: [7:0] tx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    // result: [0] frame_end
    output logic        m_tuser,
    output logic        m_tlast,
    // brightness register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data
);
    import sdre_pkg::*;

    seq_state_t       state_reg, state_next;
    logic [2:0]       row_reg, row_next;
    logic [1:0]       phase_reg, phase_next;
    logic [2:0]       bright_reg;
    logic [7:0]       digit_reg [NUM_DIGITS];
    logic             m_tvalid_reg;
    logic [7:0]       m_tdata_reg;
    logic             m_tuser_reg;
    logic             m_tlast_reg;

    logic [1:0]             in_op;
    logic [DIGIT_IDX_W-1:0] in_idx;
    logic [3:0]             in_hex;
    logic                   s_accept;
    logic                   out_free;
    logic                   emit;
    logic [7:0]             emit_byte;
    logic                   emit_fend;
    logic                   emit_last;
    logic [7:0]             col_byte;

    assign in_op  = s_tdata[1:0];
    assign in_idx = s_tdata[4:2];
    assign in_hex = s_tdata[8:5];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // Transpose unit: picks bit row_reg out of every digit
    always_comb
    begin
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            col_byte[d] = digit_reg[d][row_reg];
        end
    end

    // Sequencer: next state and byte to emit
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        phase_next = phase_reg;
        emit       = 1'b0;
        emit_byte  = CMD_DATA_FIXED;
        emit_fend  = 1'b0;
        emit_last  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                row_next   = 3'd0;
                phase_next = PH_ADDR;
                if (s_accept && in_op == OP_REFRESH)
                begin
                    state_next = ST_REFRESH;
                end
                else if (s_accept && in_op == OP_INIT)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_REFRESH:
            begin
                emit = out_free;
                unique case (phase_reg)
                    PH_ADDR:
                    begin
                        emit_byte = CMD_ADDR_BASE | {4'd0, row_reg, 1'b0};
                        emit_fend = 1'b1;
                    end
                    PH_CMD:
                    begin
                        emit_byte = CMD_DATA_FIXED;
                        emit_fend = 1'b0;
                    end
                    default:
                    begin
                        emit_byte = col_byte;
                        emit_fend = 1'b1;
                        emit_last = (row_reg == 3'd7);
                    end
                endcase
                if (out_free)
                begin
                    if (phase_reg == PH_COL)
                    begin
                        phase_next = PH_ADDR;
                        row_next   = row_reg + 3'd1;
                        if (row_reg == 3'd7)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        phase_next = phase_reg + 2'd1;
                    end
                end
            end
            ST_INIT:
            begin
                emit      = out_free;
                emit_fend = 1'b1;
                if (phase_reg == PH_ADDR)
                begin
                    emit_byte = CMD_DATA_AUTO;
                end
                else
                begin
                    emit_byte = CMD_DISP_CTRL | {5'd0, bright_reg};
                    emit_last = 1'b1;
                end
                if (out_free)
                begin
                    if (phase_reg == PH_ADDR)
                    begin
                        phase_next = PH_CMD;
                    end
                    else
                    begin
                        phase_next = PH_ADDR;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= 3'd0;
            phase_reg <= PH_ADDR;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            phase_reg <= phase_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            m_tvalid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            m_tdata_reg <= emit_byte;
            m_tuser_reg <= emit_fend;
            m_tlast_reg <= emit_last;
        end
    end

    // Brightness register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_reg <= 3'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            bright_reg <= cfg_data;
        end
    end

    // Digit store, blank at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < NUM_DIGITS; d++)
            begin
                digit_reg[d] <= 8'd0;
            end
        end
        else if (s_accept && in_op == OP_WRITE_DIGIT)
        begin
            digit_reg[in_idx] <= seg_font(in_hex);
        end
    end

`ifndef SYNTHESIS
    // Refresh only walks the three byte phases of a row
    a_refresh_phase: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_REFRESH |-> phase_reg != 2'd3)
        else $error("refresh phase out of range");

    // A refresh request starts the refresh walk
    a_refresh_start: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && in_op == OP_REFRESH |=> state_reg == ST_REFRESH && row_reg == 3'd0)
        else $error("refresh did not start at row zero");

    // Initialize never touches the row counter
    a_init_row: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INIT |-> row_reg == 3'd0)
        else $error("row counter moved during initialize");

    // Only the data command byte keeps chip enable asserted
    a_open_frame: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && !m_tuser_reg |-> m_tdata_reg == CMD_DATA_FIXED)
        else $error("open frame on a byte other than the data command");
`endif

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import sdre_pkg::*;

    // Reserved request code, must be ignored by the engine
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RUN_LIMIT     = 200000;
    localparam int SETTLE_CYCLES = 32;
    localparam int RAND_PHASES   = 5;
    localparam int PHASE_ITEMS   = 25;

    // Segment glyphs for nibbles 0..F, entry 0 in the lowest byte
    localparam logic [127:0] GLYPHS = {
        8'h71, 8'h79, 8'h5E, 8'h39, 8'h7C, 8'h77, 8'h6F, 8'h7F,
        8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
    };

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       frame_end;
        logic       last_byte;
    } tx_beat_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [15:0] s_tdata   = 16'h0000;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_data  = 3'd0;
    logic        s_tready;
    logic        m_tvalid;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_ready;

    // Shadow copy of the engine state
    logic [7:0]  shadow_digits [NUM_DIGITS];
    logic [2:0]  shadow_bright;

    logic [15:0] pending_reqs [$];
    tx_beat_t    expected_beats [$];
    logic        req_taken   = 1'b0;
    logic        calm        = 1'b0;
    int          loaded_count = 0;
    int          taken_count  = 0;
    int          mismatches   = 0;
    int          cycle_count  = 0;

    segment_display_refresh_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic [15:0] make_req(input logic [1:0] op, input logic [2:0] idx,
                                             input logic [3:0] nib);
        return {7'd0, nib, idx, op};
    endfunction

    // Update shadow state and queue the bytes a request produces
    task automatic apply_request(input logic [15:0] req);
        logic [1:0] op;
        logic [2:0] idx;
        logic [3:0] nib;
        logic [7:0] col;
        logic [7:0] row_b;
        tx_beat_t   beat;
        op  = req[1:0];
        idx = req[4:2];
        nib = req[8:5];
        case (op)
            OP_WRITE_DIGIT:
            begin
                shadow_digits[idx] = GLYPHS[nib*8 +: 8];
            end
            OP_REFRESH:
            begin
                for (int row = 0; row < 8; row++)
                begin
                    col = 8'h00;
                    for (int d = 0; d < NUM_DIGITS; d++)
                        col[d] = shadow_digits[d][row];
                    row_b = row[7:0];
                    beat = '{CMD_ADDR_BASE | (row_b << 1), 1'b1, 1'b0};
                    expected_beats.push_back(beat);
                    beat = '{CMD_DATA_FIXED, 1'b0, 1'b0};
                    expected_beats.push_back(beat);
                    beat = '{col, 1'b1, (row == 7)};
                    expected_beats.push_back(beat);
                end
            end
            OP_INIT:
            begin
                beat = '{CMD_DATA_AUTO, 1'b1, 1'b0};
                expected_beats.push_back(beat);
                beat = '{CMD_DISP_CTRL | {5'd0, shadow_bright}, 1'b1, 1'b1};
                expected_beats.push_back(beat);
            end
            default: ;
        endcase
    endtask

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Monitor: track accepted requests, config writes and check output bytes
    always @(posedge clk)
    begin : monitor
        tx_beat_t want;
        if (!rst_n)
        begin
            for (int d = 0; d < NUM_DIGITS; d++)
                shadow_digits[d] = 8'h00;
            shadow_bright = 3'd1;
            req_taken <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                shadow_bright = cfg_data;
            req_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                apply_request(s_tdata);
                taken_count = taken_count + 1;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_beats.size() == 0)
                begin
                    $display("%0t: unexpected byte, expected none, got %h user %b last %b",
                             $time, m_tdata, m_tuser, m_tlast);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (m_tdata !== want.tx_byte)
                    begin
                        $display("%0t: tx_byte expected %h got %h", $time, want.tx_byte,
                                 m_tdata);
                        mismatches = mismatches + 1;
                    end
                    if (m_tuser !== want.frame_end)
                    begin
                        $display("%0t: frame_end expected %b got %b", $time, want.frame_end,
                                 m_tuser);
                        mismatches = mismatches + 1;
                    end
                    if (m_tlast !== want.last_byte)
                    begin
                        $display("%0t: last expected %b got %b", $time, want.last_byte,
                                 m_tlast);
                        mismatches = mismatches + 1;
                    end
                end
            end
        end
    end

    // Request driver
    always @(negedge clk)
    begin
        if (!s_tvalid || req_taken)
        begin
            if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 12))
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_reqs.pop_front();
                loaded_count = loaded_count + 1;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Output back-pressure
    always @(negedge clk)
    begin
        m_tready <= calm || ($urandom_range(0, 99) >= 12);
    end

    // Wait until all requests are taken and every byte has arrived
    task automatic wait_drained();
        @(negedge clk);
        while (pending_reqs.size() != 0 || loaded_count != taken_count ||
               expected_beats.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_brightness(input logic [2:0] level);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= level;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_random_req();
        int pick;
        logic [1:0] op;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            op = OP_WRITE_DIGIT;
        else if (pick < 75)
            op = OP_REFRESH;
        else if (pick < 90)
            op = OP_INIT;
        else
            op = OP_UNUSED;
        pending_reqs.push_back(make_req(op, 3'($urandom_range(0, 7)),
                                        4'($urandom_range(0, 15))));
    endtask

    // Stimulus sequence
    initial
    begin : stimulus
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset brightness, blank store, all glyphs, ignored code
        pending_reqs.push_back(make_req(OP_INIT, 3'd0, 4'h0));
        pending_reqs.push_back(make_req(OP_REFRESH, 3'd0, 4'h0));
        for (int d = 0; d < NUM_DIGITS; d++)
            pending_reqs.push_back(make_req(OP_WRITE_DIGIT, d[2:0], d[3:0]));
        pending_reqs.push_back(make_req(OP_REFRESH, 3'd7, 4'hF));
        pending_reqs.push_back(make_req(OP_UNUSED, 3'd7, 4'hF));
        pending_reqs.push_back(make_req(OP_REFRESH, 3'd0, 4'h0));
        for (int d = 0; d < NUM_DIGITS; d++)
            pending_reqs.push_back(make_req(OP_WRITE_DIGIT, 3'(7 - d), 4'(8 + d)));
        pending_reqs.push_back(make_req(OP_REFRESH, 3'd5, 4'hA));
        pending_reqs.push_back(make_req(OP_INIT, 3'd7, 4'hF));
        wait_drained();

        // Brightness extremes
        write_brightness(3'd7);
        pending_reqs.push_back(make_req(OP_INIT, 3'd2, 4'h5));
        pending_reqs.push_back(make_req(OP_REFRESH, 3'd0, 4'h0));
        wait_drained();
        write_brightness(3'd0);
        pending_reqs.push_back(make_req(OP_INIT, 3'd5, 4'hA));
        wait_drained();

        // Random phases, one of them with no idling on either side
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            write_brightness(3'($urandom_range(0, 7)));
            calm = (ph == 2);
            for (int i = 0; i < PHASE_ITEMS; i++)
                push_random_req();
            wait_drained();
            calm = 1'b0;
        end

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> segment_display_refresh_engine.f
rtl/core/sdre_pkg.sv
rtl/core/segment_display_refresh_engine.sv
bench/tb.sv
